@@ hdl/urbd_pkg.sv @@
// ----------------------------------------------------------------------------
// urbd_pkg: shared types and constants for the UART ring buffer block
// Ring depths, pointer widths, event codes and the word layouts of both
// channels and of the transmit status that passes between modules.
// ----------------------------------------------------------------------------
package urbd_pkg;

  localparam int TX_DEPTH = 256;
  localparam int RX_DEPTH = 256;

  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int TX_LW = $clog2(TX_DEPTH + 1);
  localparam int RX_AW = $clog2(RX_DEPTH);

  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);

  // event codes carried in the mode field
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_DONE  = 2'd1;
  localparam logic [1:0] MODE_RECV  = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [7:0] rx_count;
    logic       start_transfer;
    logic [7:0] segment_offset;
    logic [8:0] segment_length;
    logic       tx_busy;
    logic       write_refused;
    logic       write_dropped;
  } out_word_t;

  typedef struct packed {
    logic       start_transfer;
    logic [7:0] segment_offset;
    logic [8:0] segment_length;
    logic       tx_busy;
    logic       write_refused;
    logic       write_dropped;
  } tx_stat_t;

endpackage

@@ hdl/urbd_tx_ctrl.sv @@
// ----------------------------------------------------------------------------
// urbd_tx_ctrl: transmit ring pointers and segment dispatch
// Tracks read/write positions, the end of the outstanding segment and the
// busy flag; produces the status for the word being processed.
// ----------------------------------------------------------------------------
module urbd_tx_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [1:0]        mode,
  output urbd_pkg::tx_stat_t stat_nxt
);

  logic [urbd_pkg::TX_AW-1:0] rp_r, rp_nxt;
  logic [urbd_pkg::TX_AW-1:0] wp_r, wp_nxt;
  logic [urbd_pkg::TX_AW-1:0] end_r, end_nxt;
  logic                       busy_r, busy_nxt;
  logic [urbd_pkg::TX_AW-1:0] wp_inc;
  logic [urbd_pkg::TX_AW-1:0] seg_off;
  logic [urbd_pkg::TX_LW-1:0] seg_len;
  logic                       try_dispatch;
  logic                       start;
  logic                       refused;
  logic                       dropped;

  always_comb begin
    wp_inc       = (wp_r == urbd_pkg::TX_LAST) ? '0 : urbd_pkg::TX_AW'(wp_r + 1'b1);
    rp_nxt       = rp_r;
    wp_nxt       = wp_r;
    end_nxt      = end_r;
    busy_nxt     = busy_r;
    refused      = 1'b0;
    dropped      = 1'b0;
    try_dispatch = 1'b0;
    start        = 1'b0;
    seg_off      = '0;
    seg_len      = '0;

    unique case (mode)
      urbd_pkg::MODE_WRITE: begin
        if (busy_r) begin
          refused = 1'b1;
        end else begin
          // full ring keeps one slot spare: byte is lost
          if (wp_inc == rp_r) begin
            dropped = 1'b1;
          end else begin
            wp_nxt = wp_inc;
          end
          try_dispatch = 1'b1;
        end
      end
      urbd_pkg::MODE_DONE: begin
        if (busy_r) begin
          busy_nxt     = 1'b0;
          rp_nxt       = end_r;
          try_dispatch = 1'b1;
        end
      end
      urbd_pkg::MODE_RECV,
      urbd_pkg::MODE_READ: begin
      end
      default: begin
      end
    endcase

    if (try_dispatch && (wp_nxt != rp_nxt)) begin
      start    = 1'b1;
      seg_off  = rp_nxt;
      busy_nxt = 1'b1;
      if (wp_nxt > rp_nxt) begin
        seg_len = urbd_pkg::TX_LW'(wp_nxt - rp_nxt);
        end_nxt = wp_nxt;
      end else begin
        // wrapped data: run to the end of the store
        seg_len = urbd_pkg::TX_LW'(urbd_pkg::TX_DEPTH) - urbd_pkg::TX_LW'(rp_nxt);
        end_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r   <= '0;
      wp_r   <= '0;
      end_r  <= '0;
      busy_r <= 1'b0;
    end else if (step) begin
      rp_r   <= rp_nxt;
      wp_r   <= wp_nxt;
      end_r  <= end_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign stat_nxt.start_transfer = start;
  assign stat_nxt.segment_offset = 8'(seg_off);
  assign stat_nxt.segment_length = 9'(seg_len);
  assign stat_nxt.tx_busy        = busy_nxt;
  assign stat_nxt.write_refused  = refused;
  assign stat_nxt.write_dropped  = dropped;

endmodule

@@ hdl/urbd_rx_ring.sv @@
// ----------------------------------------------------------------------------
// urbd_rx_ring: receive ring store and pointers
// Appends received bytes, serves host reads through a registered read port
// and reports the fill count after each word.
// ----------------------------------------------------------------------------
module urbd_rx_ring (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [1:0] mode,
  input  logic [7:0] data_byte,
  output logic [7:0] count_nxt,
  output logic [7:0] read_byte
);

  logic [7:0]                 mem [urbd_pkg::RX_DEPTH];
  logic [urbd_pkg::RX_DEPTH-1:0] vld_r;
  logic [urbd_pkg::RX_AW-1:0] rp_r, rp_nxt;
  logic [urbd_pkg::RX_AW-1:0] wp_r, wp_nxt;
  logic [urbd_pkg::RX_AW-1:0] diff;
  logic [7:0]                 rd_data_r;
  logic                       rd_hit_r;
  logic                       is_recv;
  logic                       is_read;

  assign is_recv = (mode == urbd_pkg::MODE_RECV);
  assign is_read = (mode == urbd_pkg::MODE_READ);

  always_comb begin
    rp_nxt = rp_r;
    wp_nxt = wp_r;
    if (is_recv) begin
      // no overflow check: a full ring reads as empty
      wp_nxt = (wp_r == urbd_pkg::RX_LAST) ? '0 : urbd_pkg::RX_AW'(wp_r + 1'b1);
    end
    if (is_read && (rp_r != wp_r)) begin
      rp_nxt = (rp_r == urbd_pkg::RX_LAST) ? '0 : urbd_pkg::RX_AW'(rp_r + 1'b1);
    end
    if (wp_nxt >= rp_nxt) begin
      diff = urbd_pkg::RX_AW'(wp_nxt - rp_nxt);
    end else begin
      diff = urbd_pkg::RX_AW'(urbd_pkg::RX_DEPTH - int'(rp_nxt) + int'(wp_nxt));
    end
    count_nxt = (int'(diff) > 255) ? 8'hff : 8'(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r  <= '0;
      wp_r  <= '0;
      vld_r <= '0;
    end else if (step) begin
      rp_r <= rp_nxt;
      wp_r <= wp_nxt;
      if (is_recv) begin
        vld_r[wp_r] <= 1'b1;
      end
    end
  end

  // store array and registered read port; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (step && is_recv) begin
      mem[wp_r] <= data_byte;
    end
    if (step) begin
      rd_data_r <= mem[rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_hit_r <= 1'b0;
    end else if (step) begin
      rd_hit_r <= is_read && vld_r[rp_r];
    end
  end

  assign read_byte = rd_hit_r ? rd_data_r : 8'h00;

endmodule

@@ hdl/uart_ring_buffer_dma_dispatch_top.sv @@
// ----------------------------------------------------------------------------
// uart_ring_buffer_dma_dispatch_top: UART rings with transmit segment dispatch
// Input register, pointer logic for both rings and a result register.
// ----------------------------------------------------------------------------
// One result word per input word. The block takes a word every cycle while
// the result register is free to take a result; a word is held in the input
// register and its result is then registered in the result register. The rate
// is set by the pointer update of each ring and the one registered read of
// the receive store per word. After reset the receive store reads as zeros
// through per-entry valid bits, so no clearing pass is needed.
module uart_ring_buffer_dma_dispatch_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  urbd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output urbd_pkg::out_word_t out_data
);

  urbd_pkg::in_word_t in_r;
  logic               in_valid_r;
  logic               out_valid_r;
  logic               out_free;
  logic               step;
  urbd_pkg::tx_stat_t tx_nxt;
  urbd_pkg::tx_stat_t tx_r;
  logic [7:0]         count_nxt;
  logic [7:0]         count_r;
  logic [7:0]         rd_byte;

  assign out_free = !out_valid_r || out_ready;
  assign step     = in_valid_r && out_free;
  assign in_ready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  urbd_tx_ctrl u_tx (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .mode     (in_r.mode),
    .stat_nxt (tx_nxt)
  );

  urbd_rx_ring u_rx (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .mode      (in_r.mode),
    .data_byte (in_r.data_byte),
    .count_nxt (count_nxt),
    .read_byte (rd_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      tx_r    <= tx_nxt;
      count_r <= count_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_data.read_byte      = rd_byte;
  assign out_data.rx_count       = count_r;
  assign out_data.start_transfer = tx_r.start_transfer;
  assign out_data.segment_offset = tx_r.segment_offset;
  assign out_data.segment_length = tx_r.segment_length;
  assign out_data.tx_busy        = tx_r.tx_busy;
  assign out_data.write_refused  = tx_r.write_refused;
  assign out_data.write_dropped  = tx_r.write_dropped;

  // a refused write leaves the transfer outstanding
  a_refused_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.write_refused |-> out_data.tx_busy)
    else $error("refused write without busy transfer");

  // a requested segment is never empty and marks the transfer busy
  a_start_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.start_transfer |->
      out_data.tx_busy && (out_data.segment_length != 9'd0))
    else $error("segment request with no length or not busy");

  a_drop_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.write_dropped && out_data.write_refused))
    else $error("write both dropped and refused");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result pending after reset");

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for uart_ring_buffer_dma_dispatch_top
// A mirror of the transmit and receive rings predicts one result word per
// accepted input word. Directed events cover the corner cases first. Random
// traffic follows, mostly write/complete pairs and receive/read bursts, under
// changing sender gaps and receiver stalls, including one long receiver hold.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;

  class uart_ring_mirror;
    logic [urbd_pkg::TX_AW-1:0] tx_rd;
    logic [urbd_pkg::TX_AW-1:0] tx_wr;
    logic [urbd_pkg::TX_AW-1:0] tx_seg_end;
    logic                       tx_busy;
    logic [7:0]                 rx_mem [urbd_pkg::RX_DEPTH];
    logic [urbd_pkg::RX_AW-1:0] rx_rd;
    logic [urbd_pkg::RX_AW-1:0] rx_wr;
    urbd_pkg::out_word_t        expected_words [$];
    int                         errors;
    int                         tx_wraps;
    int                         rx_overflows;

    function new();
      tx_rd = '0;
      tx_wr = '0;
      tx_seg_end = '0;
      tx_busy = 1'b0;
      rx_rd = '0;
      rx_wr = '0;
      foreach (rx_mem[i]) rx_mem[i] = 8'h00;
      errors = 0;
      tx_wraps = 0;
      rx_overflows = 0;
    endfunction

    // start a segment from the read position, up to the write position or
    // to the end of the store when the data wraps
    function bit start_segment(output logic [7:0] off, output logic [8:0] len);
      off = '0;
      len = '0;
      if (tx_busy || tx_wr == tx_rd) return 1'b0;
      off = 8'(tx_rd);
      if (tx_wr > tx_rd) begin
        len = 9'(int'(tx_wr) - int'(tx_rd));
        tx_seg_end = tx_wr;
      end else begin
        len = 9'(urbd_pkg::TX_DEPTH - int'(tx_rd));
        tx_seg_end = '0;
        tx_wraps++;
      end
      tx_busy = 1'b1;
      return 1'b1;
    endfunction

    function void note_event(urbd_pkg::in_word_t w);
      urbd_pkg::out_word_t        r;
      logic [urbd_pkg::TX_AW-1:0] nxt;
      logic [7:0]                 off;
      logic [8:0]                 len;
      int                         cnt;
      r = '0;
      case (w.mode)
        urbd_pkg::MODE_WRITE: begin
          if (tx_busy) begin
            r.write_refused = 1'b1;
          end else begin
            nxt = tx_wr + 1'b1;
            if (nxt == tx_rd) r.write_dropped = 1'b1;
            else tx_wr = nxt;
            if (start_segment(off, len)) begin
              r.start_transfer = 1'b1;
              r.segment_offset = off;
              r.segment_length = len;
            end
          end
        end
        urbd_pkg::MODE_DONE: begin
          // completion with nothing outstanding changes nothing
          if (tx_busy) begin
            tx_busy = 1'b0;
            tx_rd = tx_seg_end;
            if (start_segment(off, len)) begin
              r.start_transfer = 1'b1;
              r.segment_offset = off;
              r.segment_length = len;
            end
          end
        end
        urbd_pkg::MODE_RECV: begin
          rx_mem[rx_wr] = w.data_byte;
          rx_wr = rx_wr + 1'b1;
          if (rx_wr == rx_rd) rx_overflows++;
        end
        default: begin
          r.read_byte = rx_mem[rx_rd];
          if (rx_rd != rx_wr) rx_rd = rx_rd + 1'b1;
        end
      endcase
      cnt = (int'(rx_wr) - int'(rx_rd) + urbd_pkg::RX_DEPTH) % urbd_pkg::RX_DEPTH;
      if (cnt > 255) cnt = 255;
      r.rx_count = 8'(cnt);
      r.tx_busy = tx_busy;
      expected_words.push_back(r);
    endfunction

    function bit field_ok(string name, logic [8:0] e, logic [8:0] a);
      if (e !== a) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_result(urbd_pkg::out_word_t got);
      urbd_pkg::out_word_t e;
      bit                  ok;
      if (expected_words.size() == 0) begin
        $display("%0t: result word with none expected, expected none, actual %0h",
                 $time, got);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      ok = 1'b1;
      ok &= field_ok("read_byte", e.read_byte, got.read_byte);
      ok &= field_ok("rx_count", e.rx_count, got.rx_count);
      ok &= field_ok("start_transfer", e.start_transfer, got.start_transfer);
      ok &= field_ok("segment_offset", e.segment_offset, got.segment_offset);
      ok &= field_ok("segment_length", e.segment_length, got.segment_length);
      ok &= field_ok("tx_busy", e.tx_busy, got.tx_busy);
      ok &= field_ok("write_refused", e.write_refused, got.write_refused);
      ok &= field_ok("write_dropped", e.write_dropped, got.write_dropped);
      if (!ok) errors++;
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  urbd_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  urbd_pkg::out_word_t out_data;

  uart_ring_mirror ring = new();

  int cycles = 0;
  int results_seen = 0;
  int words_sent = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  uart_ring_buffer_dma_dispatch_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold so the input side backs up
  always @(posedge clk) begin
    if (!hold_done && results_seen >= 300) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("uart_ring_buffer_dma_dispatch_top test failed");
      $finish;
    end else if (rst_n && out_valid && out_ready) begin
      ring.check_result(out_data);
      results_seen <= results_seen + 1;
    end
  end

  task automatic post(input logic [1:0] mode, input logic [7:0] b);
    urbd_pkg::in_word_t w;
    w.mode = mode;
    w.data_byte = b;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ring.note_event(w);
    words_sent++;
  endtask

  task automatic random_traffic();
    int pick;
    while ((words_sent < RANDOM_ITEMS || ring.tx_wraps == 0 || ring.rx_overflows == 0)
           && words_sent < RANDOM_ITEMS + RANDOM_ITEMS / 4) begin
      case ((words_sent / 200) % 4)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 53;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 53;
        end
        default: begin
          gap_pct = 26;
          stall_pct = 26;
        end
      endcase
      pick = $urandom_range(999);
      if (pick < 4) begin
        // enough received bytes back to back to lap the receive ring
        repeat ($urandom_range(280, 256)) begin
          post(urbd_pkg::MODE_RECV, 8'($urandom_range(255)));
        end
      end else if (pick < 550) begin
        post(urbd_pkg::MODE_WRITE, 8'($urandom_range(255)));
        if ($urandom_range(3) == 0) post(urbd_pkg::MODE_WRITE, 8'($urandom_range(255)));
        post(urbd_pkg::MODE_DONE, 8'($urandom_range(255)));
      end else if (pick < 700) begin
        repeat ($urandom_range(6, 1)) post(urbd_pkg::MODE_RECV, 8'($urandom_range(255)));
      end else if (pick < 850) begin
        repeat ($urandom_range(6, 1)) post(urbd_pkg::MODE_READ, 8'($urandom_range(255)));
      end else begin
        post(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    post(urbd_pkg::MODE_READ, 8'h00);   // read of an empty ring
    post(urbd_pkg::MODE_DONE, 8'hFF);   // completion with nothing outstanding
    post(urbd_pkg::MODE_WRITE, 8'h00);
    post(urbd_pkg::MODE_WRITE, 8'hFF);  // refused while busy
    post(urbd_pkg::MODE_DONE, 8'h00);
    post(urbd_pkg::MODE_DONE, 8'h55);
    post(urbd_pkg::MODE_WRITE, 8'hA5);
    post(urbd_pkg::MODE_DONE, 8'h5A);
    post(urbd_pkg::MODE_RECV, 8'hFF);
    post(urbd_pkg::MODE_RECV, 8'h00);
    post(urbd_pkg::MODE_RECV, 8'h5A);
    post(urbd_pkg::MODE_READ, 8'hFF);
    post(urbd_pkg::MODE_READ, 8'h00);
    post(urbd_pkg::MODE_READ, 8'hA5);
    post(urbd_pkg::MODE_READ, 8'h3C);   // empty again, pointer holds
    post(urbd_pkg::MODE_RECV, 8'h80);
    post(urbd_pkg::MODE_READ, 8'h7F);

    random_traffic();
    in_valid <= 1'b0;

    while (ring.expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (ring.errors == 0 && ring.expected_words.size() == 0) begin
      $display("uart_ring_buffer_dma_dispatch_top test passed");
    end else begin
      $display("uart_ring_buffer_dma_dispatch_top test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/urbd_pkg.sv
hdl/urbd_tx_ctrl.sv
hdl/urbd_rx_ring.sv
hdl/uart_ring_buffer_dma_dispatch_top.sv
verif/testbench.sv
